@@ rtl/core/cdrc_pkg.sv @@
package cdrc_pkg;

  // Field widths.
  localparam int unsigned FREQ_W = 12;
  localparam int unsigned FRAC_W = 3;
  localparam int unsigned QUO_W  = FREQ_W + FRAC_W;
  localparam int unsigned WORD_W = 32;

  // One long-division cell per quotient bit of 8*source / request.
  localparam int unsigned DIV_STEPS = QUO_W;

  // Byte address of the source frequency register on the configuration port.
  localparam logic [1:0] SOURCE_ADDR = 2'd0;

  // Register addresses carried in the top byte of each word.
  localparam logic [7:0] ADDR_COUNT = 8'h08;
  localparam logic [7:0] ADDR_FRAC  = 8'h09;
  localparam logic [7:0] ADDR_PHASE = 8'h07;

  // Largest integer ratio that still fits the 6-bit counts.
  localparam logic [FREQ_W-1:0] MAX_DIV = 12'd126;

  // 8*source == 17*request marks a ratio of exactly 2.125.
  localparam logic [QUO_W-1:0] QUO_2125 = 15'd17;

  // Word counts.
  localparam logic [1:0] COUNT_EXACT = 2'd2;
  localparam logic [1:0] COUNT_FRAC  = 2'd3;

  // Reset value of the source frequency register.
  localparam logic [FREQ_W-1:0] SOURCE_RESET = 12'd800;

  // Data handed from one division cell to the next.
  typedef struct packed {
    logic              valid;
    logic              err;
    logic [FREQ_W-1:0] rem;
    logic [QUO_W-1:0]  num;
    logic [QUO_W-1:0]  quo;
    logic [FREQ_W-1:0] den;
  } div_stage_t;

endpackage

@@ rtl/core/clock_divider_register_calc_core.sv @@
// A request accepted at a clock edge passes through 15 long-division cells, the
// first loaded at the accepting edge, and then the output register.
// Throughput: one request per cycle; the whole chain holds while a result stalls.
// Reset (rst, synchronous, active high) empties the chain, holds off requests and
// sets the source frequency register to 800.
module clock_divider_register_calc_core
  import cdrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Request channel.
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [FREQ_W-1:0] target_freq,
  // Result channel.
  output logic              res_valid,
  input  logic              res_stall,
  output logic [WORD_W-1:0] word_hi_lo,
  output logic [WORD_W-1:0] word_frac,
  output logic [WORD_W-1:0] word_phase,
  output logic [1:0]        word_count,
  output logic              error
);

  logic [FREQ_W-1:0] source_freq;
  logic              adv;
  div_stage_t        chain [DIV_STEPS+1];

  // Configuration register at byte address zero; reads always return it.
  assign pready = 1'b1;
  assign prdata = {20'd0, source_freq};

  always_ff @(posedge clk) begin
    if (rst) begin
      source_freq <= SOURCE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == SOURCE_ADDR)) begin
      source_freq <= pwdata[FREQ_W-1:0];
    end
  end

  // The chain moves unless a finished result is waiting.
  assign adv       = !(res_valid && res_stall);
  assign req_stall = !adv || rst;

  // Entry of the chain: dividend is 8*source, early errors flagged here.
  always_comb begin
    chain[0].valid = req_valid;
    chain[0].err   = (target_freq == '0) || (target_freq > source_freq);
    chain[0].rem   = '0;
    chain[0].num   = {source_freq, {FRAC_W{1'b0}}};
    chain[0].quo   = '0;
    chain[0].den   = target_freq;
  end

  // One cell per quotient bit.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
    cdrc_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .stage_in  (chain[k]),
      .stage_out (chain[k+1])
    );
  end

  cdrc_format u_format (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .stage_in   (chain[DIV_STEPS]),
    .res_valid  (res_valid),
    .word_hi_lo (word_hi_lo),
    .word_frac  (word_frac),
    .word_phase (word_phase),
    .word_count (word_count),
    .error      (error)
  );

`ifndef SYNTHESIS
  // An error result carries nothing to write.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && error |-> word_count == '0 && word_hi_lo == '0)
    else $error("error result carries register words");

  // A good result always enables the counter and names two or three words.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !error |-> word_hi_lo[20] &&
      (word_count == COUNT_EXACT || word_count == COUNT_FRAC))
    else $error("good result with bad count word");

  // An exact ratio never sets a phase or fall flag.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !error && word_count == COUNT_EXACT |-> word_phase[23:8] == '0)
    else $error("exact ratio with nonzero phase register");

  // Words agree on the count carried in their low byte.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> word_frac[1:0] == word_count && word_phase[1:0] == word_count)
    else $error("count byte mismatch between words");
`endif

endmodule

@@ rtl/core/cdrc_div_cell.sv @@
module cdrc_div_cell
  import cdrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  div_stage_t stage_in,
  output div_stage_t stage_out
);

  logic [FREQ_W:0]   trial;
  logic [FREQ_W:0]   diff;
  logic              ge;
  div_stage_t        stage_next;

  // One restoring step: bring down the next dividend bit and try to subtract.
  always_comb begin
    trial = {stage_in.rem, stage_in.num[QUO_W-1]};
    diff  = trial - {1'b0, stage_in.den};
    ge    = (trial >= {1'b0, stage_in.den});
    stage_next       = stage_in;
    stage_next.rem   = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
    stage_next.num   = {stage_in.num[QUO_W-2:0], 1'b0};
    stage_next.quo   = {stage_in.quo[QUO_W-2:0], ge};
  end

  // Valid is control state and is cleared by reset; the rest is payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (adv) begin
      stage_out.valid <= stage_next.valid;
    end
    if (adv) begin
      stage_out.err <= stage_next.err;
      stage_out.rem <= stage_next.rem;
      stage_out.num <= stage_next.num;
      stage_out.quo <= stage_next.quo;
      stage_out.den <= stage_next.den;
    end
  end

endmodule

@@ rtl/core/cdrc_format.sv @@
module cdrc_format
  import cdrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  div_stage_t        stage_in,
  output logic              res_valid,
  output logic [WORD_W-1:0] word_hi_lo,
  output logic [WORD_W-1:0] word_frac,
  output logic [WORD_W-1:0] word_phase,
  output logic [1:0]        word_count,
  output logic              error
);

  logic [FREQ_W-1:0] div;
  logic [FRAC_W-1:0] frac;
  logic              rem_nz;
  logic              odd;
  logic              is_2125;
  logic              err_all;
  logic [5:0]        half;
  logic [5:0]        hi;
  logic [5:0]        lo;
  logic [3:0]        e;
  logic              rise;
  logic              fall;
  logic [15:0]       reg_cnt;
  logic [15:0]       reg_frac;
  logic [15:0]       reg_phase;
  logic [1:0]        count;

  // Split the quotient into integer part and eighths, then build the registers.
  always_comb begin
    div     = stage_in.quo[QUO_W-1:FRAC_W];
    frac    = stage_in.quo[FRAC_W-1:0];
    rem_nz  = (frac != '0) || (stage_in.rem != '0);
    odd     = div[0];
    is_2125 = (stage_in.quo == QUO_2125) && (stage_in.rem == '0);
    err_all = stage_in.err || (div > MAX_DIV) || (rem_nz && (div < 12'd2));
    half    = div[6:1];
    e       = {odd, frac};
    rise    = (e >= 4'd1) && (e <= 4'd8);
    fall    = ((e >= 4'd2) && (e <= 4'd9)) || is_2125;
    if (!rem_nz) begin
      count     = COUNT_EXACT;
      hi        = half;
      lo        = half + {5'd0, odd};
      reg_frac  = {8'd0, odd, 7'd0};
      reg_phase = '0;
    end else begin
      count     = COUNT_FRAC;
      hi        = (e <= 4'd8) ? half - 6'd1 : half;
      lo        = (e <= 4'd9) ? half - 6'd1 : half;
      reg_frac  = {1'b0, frac, 1'b1, rise, 10'd0};
      reg_phase = {2'b00, odd, frac[2:1], fall, 10'd0};
    end
    reg_cnt = {4'b0001, hi, lo};
  end

  // Output register; it holds while the result is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (err_all) begin
        word_hi_lo <= '0;
        word_frac  <= '0;
        word_phase <= '0;
        word_count <= '0;
        error      <= 1'b1;
      end else begin
        word_hi_lo <= {ADDR_COUNT, reg_cnt, 6'd0, count};
        word_frac  <= {ADDR_FRAC, reg_frac, 6'd0, count};
        word_phase <= {ADDR_PHASE, reg_phase, 6'd0, count};
        word_count <= count;
        error      <= 1'b0;
      end
    end
  end

endmodule

@@ test/clock_divider_register_calc_core_tb.sv @@
`timescale 1ns / 1ps

module clock_divider_register_calc_core_tb
  import cdrc_pkg::*;
();

  // Sizes the wait for late results at the end of the run.
  localparam int RESULT_LATENCY = 15;
  localparam int PHASE_REQUESTS = 64;

  typedef struct packed {
    logic [WORD_W-1:0] hi_lo;
    logic [WORD_W-1:0] frac;
    logic [WORD_W-1:0] phase;
    logic [1:0]        count;
    logic              err;
  } divider_words_t;

  typedef struct packed {
    logic              set_source;
    logic [FREQ_W-1:0] source;
    logic [FREQ_W-1:0] target;
    logic              typed;
    divider_words_t    want;
  } directed_row_t;

  localparam divider_words_t REJECTED = '{32'h0, 32'h0, 32'h0, 2'd0, 1'b1};
  localparam divider_words_t UNUSED   = '{32'h0, 32'h0, 32'h0, 2'd0, 1'b0};
  // Ratio of exactly one: odd count pair 0/1 with the edge bit set.
  localparam divider_words_t RATIO_ONE =
    '{32'h08100102, 32'h09008002, 32'h07000002, COUNT_EXACT, 1'b0};

  logic              clk;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [1:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic [FREQ_W-1:0] target_freq = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  logic [WORD_W-1:0] word_hi_lo;
  logic [WORD_W-1:0] word_frac;
  logic [WORD_W-1:0] word_phase;
  logic [1:0]        word_count;
  logic              error;

  // Expectation typed in by the directed table travels with the request.
  logic              want_typed = 1'b0;
  divider_words_t    want_fixed = '0;

  int unsigned    source_model;
  divider_words_t pending_words[$];
  int             mismatches = 0;
  int unsigned    idle_pct = 36;

  clock_divider_register_calc_core dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .target_freq(target_freq),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .word_hi_lo (word_hi_lo),
    .word_frac  (word_frac),
    .word_phase (word_phase),
    .word_count (word_count),
    .error      (error)
  );

  // Directed requests: limits, every count branch, rejections and the 2.125 ratio.
  directed_row_t directed_rows[] = '{
    '{1'b0, 12'd0,    12'd0,    1'b1, REJECTED},
    '{1'b0, 12'd0,    12'd801,  1'b1, REJECTED},
    '{1'b0, 12'd0,    12'd4095, 1'b1, REJECTED},
    '{1'b0, 12'd0,    12'd800,  1'b1, RATIO_ONE},
    '{1'b0, 12'd0,    12'd400,  1'b1,
      '{32'h08104102, 32'h09000002, 32'h07000002, COUNT_EXACT, 1'b0}},
    '{1'b0, 12'd0,    12'd401,  1'b1, REJECTED},
    '{1'b0, 12'd0,    12'd6,    1'b1, REJECTED},
    '{1'b0, 12'd0,    12'd7,    1'b0, UNUSED},
    '{1'b0, 12'd0,    12'd33,   1'b0, UNUSED},
    '{1'b0, 12'd0,    12'd250,  1'b0, UNUSED},
    '{1'b0, 12'd0,    12'd266,  1'b0, UNUSED},
    '{1'b0, 12'd0,    12'd399,  1'b0, UNUSED},
    '{1'b0, 12'd0,    12'd205,  1'b0, UNUSED},
    '{1'b1, 12'd4095, 12'd4095, 1'b1, RATIO_ONE},
    '{1'b0, 12'd0,    12'd1,    1'b1, REJECTED},
    '{1'b0, 12'd0,    12'd33,   1'b0, UNUSED},
    '{1'b0, 12'd0,    12'd4094, 1'b1, REJECTED},
    '{1'b1, 12'd1,    12'd1,    1'b1, RATIO_ONE},
    '{1'b0, 12'd0,    12'd2,    1'b1, REJECTED},
    '{1'b1, 12'd126,  12'd1,    1'b1,
      '{32'h081FFF02, 32'h09000002, 32'h07000002, COUNT_EXACT, 1'b0}},
    '{1'b0, 12'd0,    12'd63,   1'b0, UNUSED},
    '{1'b1, 12'd127,  12'd1,    1'b1, REJECTED},
    '{1'b0, 12'd0,    12'd2,    1'b0, UNUSED},
    '{1'b1, 12'd136,  12'd64,   1'b0, UNUSED},
    '{1'b0, 12'd0,    12'd17,   1'b0, UNUSED}
  };

  // Computes the counter register words for one request at a given source.
  function automatic divider_words_t calc_divider_words(int unsigned src, int unsigned req);
    divider_words_t w;
    int unsigned    quo;
    int unsigned    rmd;
    int unsigned    odd;
    int unsigned    hi;
    int unsigned    lo;
    int unsigned    eighths;
    int unsigned    pos;
    logic           rise;
    logic           fall;
    logic [15:0]    cnt_reg;
    logic [15:0]    frac_reg;
    logic [15:0]    phase_reg;
    logic [1:0]     cnt;
    w = REJECTED;
    if (req == 0 || req > src) return w;
    quo = src / req;
    rmd = src % req;
    if (quo > MAX_DIV || (rmd != 0 && quo < 2)) return w;
    odd = quo & 1;
    hi = quo / 2;
    lo = quo / 2;
    if (rmd == 0) begin
      cnt = COUNT_EXACT;
      lo = lo + odd;
      frac_reg = {8'd0, 1'(odd), 7'd0};
      phase_reg = '0;
    end else begin
      cnt = COUNT_FRAC;
      eighths = (8 * rmd) / req;
      pos = odd * 8 + eighths;
      // Counts shrink by one when the fractional edge lands early.
      if (pos <= 8) begin
        hi = hi - 1;
        lo = lo - 1;
      end else if (pos == 9) begin
        lo = lo - 1;
      end
      rise = (pos >= 1 && pos <= 8);
      fall = (pos >= 2 && pos <= 9) || (8 * src == 17 * req);
      frac_reg = {1'b0, 3'(eighths), 1'b1, rise, 10'd0};
      phase_reg = {2'b00, 3'((odd * 4 + eighths / 2) & 7), fall, 10'd0};
    end
    // Count register: enable bit 12, high count, low count.
    cnt_reg = {4'b0001, 6'(hi), 6'(lo)};
    w.hi_lo = {ADDR_COUNT, cnt_reg, 6'd0, cnt};
    w.frac  = {ADDR_FRAC, frac_reg, 6'd0, cnt};
    w.phase = {ADDR_PHASE, phase_reg, 6'd0, cnt};
    w.count = cnt;
    w.err   = 1'b0;
    return w;
  endfunction

  // Picks a request that mostly lands in the serviceable range of the source.
  function automatic logic [FREQ_W-1:0] pick_target(int unsigned src);
    int unsigned sel;
    int unsigned d;
    int unsigned t;
    int unsigned lo;
    sel = $urandom_range(99);
    if (sel < 25) return 12'($urandom_range(4095));
    if (sel < 35 && src % 17 == 0) return 12'(8 * src / 17);
    if (sel < 70) begin
      d = $urandom_range(130, 1);
      t = src / d;
      if (t == 0) t = 1;
      t = t + $urandom_range(2);
      if (t > 1) t = t - 1;
      if (t > 4095) t = 4095;
      return 12'(t);
    end
    lo = src / 127 + 1;
    if (lo > src) lo = src;
    return 12'($urandom_range(src, lo));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_request(input logic [FREQ_W-1:0] t, input logic typed,
                              input divider_words_t fixed);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    target_freq <= t;
    want_typed  <= typed;
    want_fixed  <= fixed;
    do @(posedge clk); while (req_stall);
  endtask

  // Holds off new requests until every outstanding result has been taken.
  task automatic finish_pending();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  task automatic write_source(input logic [FREQ_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SOURCE_ADDR;
    pwdata  <= {20'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Track the source register and queue the expected words of each accepted request.
  always @(posedge clk) begin
    if (rst) begin
      source_model = SOURCE_RESET;
    end else begin
      if (psel && penable && pwrite && pready && paddr == SOURCE_ADDR)
        source_model = pwdata[FREQ_W-1:0];
      if (req_valid && !req_stall) begin
        if (want_typed)
          pending_words.push_back(want_fixed);
        else
          pending_words.push_back(calc_divider_words(source_model, target_freq));
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    divider_words_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_words.pop_front();
        if (word_hi_lo !== want.hi_lo)
          report_mismatch($sformatf("word_hi_lo %h, want %h", word_hi_lo, want.hi_lo));
        if (word_frac !== want.frac)
          report_mismatch($sformatf("word_frac %h, want %h", word_frac, want.frac));
        if (word_phase !== want.phase)
          report_mismatch($sformatf("word_phase %h, want %h", word_phase, want.phase));
        if (word_count !== want.count)
          report_mismatch($sformatf("word_count %0d, want %0d", word_count, want.count));
        if (error !== want.err)
          report_mismatch($sformatf("error %b, want %b", error, want.err));
      end
    end
  end

  // Result side stalls at random.
  always @(posedge clk) begin
    res_stall <= !rst && ($urandom_range(99) < idle_pct);
  end

  // Main sequence.
  initial begin
    logic [FREQ_W-1:0] sources[7];
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, starting on the reset value of the source.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_source) begin
        finish_pending();
        write_source(directed_rows[i].source);
      end
      send_request(directed_rows[i].target, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases, each at its own source frequency.
    sources[0] = 12'd4095;
    sources[1] = 12'd1;
    sources[2] = 12'd800;
    sources[3] = 12'(17 * $urandom_range(240, 1));
    sources[4] = 12'd2048;
    sources[5] = 12'($urandom_range(4095, 1));
    sources[6] = 12'd200;
    foreach (sources[p]) begin
      finish_pending();
      write_source(sources[p]);
      // One phase runs with neither side idling.
      idle_pct = (p == 2) ? 0 : 36;
      repeat (PHASE_REQUESTS) send_request(pick_target(sources[p]), 1'b0, UNUSED);
    end

    finish_pending();
    repeat (2 * RESULT_LATENCY) @(posedge clk);
    if (pending_words.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_words.size()));
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/cdrc_pkg.sv
rtl/core/cdrc_div_cell.sv
rtl/core/cdrc_format.sv
rtl/core/clock_divider_register_calc_core.sv
test/clock_divider_register_calc_core_tb.sv
